// ===== hdl/hjs_pkg.sv =====
// Shared constants and types of the HRRN job scheduler.
`default_nettype none
package hjs_pkg;

    localparam int MAX_PROCS_DEF  = 16;
    localparam int TIME_WIDTH_DEF = 16;

    localparam int IN_FIELD_W = 16;
    localparam int S_TDATA_W  = 32;

    localparam int OUT_IDX_W  = 6;
    localparam int OUT_TIME_W = 21;
    localparam int M_TDATA_W  = 96;

    localparam logic [OUT_TIME_W-1:0] OUT_MAX = {OUT_TIME_W{1'b1}};

    typedef struct packed {
        logic mul_first;
        logic mul_second;
    } cmp_ctrl_t;

endpackage
`default_nettype wire

// ===== hdl/hjs_job_mem.sv =====
// Job store: arrival and burst per slot, one write and one registered read port.
`default_nettype none
module hjs_job_mem #(
    parameter int DEPTH = hjs_pkg::MAX_PROCS_DEF,
    parameter int AW    = $clog2(hjs_pkg::MAX_PROCS_DEF),
    parameter int DW    = 2 * hjs_pkg::TIME_WIDTH_DEF
) (
    input  wire logic          aclk,
    input  wire logic          we,
    input  wire logic [AW-1:0] waddr,
    input  wire logic [DW-1:0] wdata,
    input  wire logic [AW-1:0] raddr,
    output logic      [DW-1:0] rdata
);

    logic [DW-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

// ===== hdl/hjs_cmp_unit.sv =====
// Shared multiplier and response-ratio compare of a candidate against the current best.
`default_nettype none
module hjs_cmp_unit #(
    parameter int NUM_W = 22,
    parameter int SW    = hjs_pkg::TIME_WIDTH_DEF
) (
    input  wire logic              aclk,
    input  wire hjs_pkg::cmp_ctrl_t ctrl,
    input  wire logic [NUM_W-1:0]  cand_num,
    input  wire logic [NUM_W-1:0]  best_num,
    input  wire logic [SW-1:0]     cand_bur,
    input  wire logic [SW-1:0]     best_bur,
    input  wire logic [SW-1:0]     cand_arr,
    input  wire logic [SW-1:0]     best_arr,
    output logic                   cand_wins
);

    localparam int PW = NUM_W + SW;

    logic [NUM_W-1:0] mul_a;
    logic [SW-1:0]    mul_b;
    logic [PW-1:0]    mul_out;
    logic [PW-1:0]    p_reg, p_next;
    logic [PW-1:0]    q_reg, q_next;

    always_comb begin
        mul_a   = ctrl.mul_first ? cand_num : best_num;
        mul_b   = ctrl.mul_first ? best_bur : cand_bur;
        mul_out = mul_a * mul_b;
        p_next  = ctrl.mul_first ? mul_out : p_reg;
        q_next  = ctrl.mul_second ? mul_out : q_reg;
    end

    always_ff @(posedge aclk) begin
        p_reg <= p_next;
        q_reg <= q_next;
    end

    assign cand_wins = (p_reg > q_reg) || ((p_reg == q_reg) && (cand_arr < best_arr));

endmodule
`default_nettype wire

// ===== hdl/hrrn_job_scheduler_top.sv =====
// Top level of the non-preemptive highest-response-ratio-next job scheduler.
//
// Input stream: each word loads one job (arrival, burst) into the next free slot,
// one word per cycle while the block is idle. Jobs beyond MAX_PROCS are dropped
// and m_tuser reports the drop on every result of that set. A word with s_tlast
// set closes the set; s_tready stays low until the whole schedule has been sent.
// Output stream: one word per held job in run order, m_tlast on the final one.
// Scheduling: each result scans all n held jobs through one registered-read port:
// a job that is done, not ready or the first ready one passes RD and EVAL only;
// each further ready job also goes through MUL1, MUL2 and CMP on the shared
// multiplier (two products, one compare); DECIDE then builds the result and OUT
// presents the word. When no job is ready the time jumps to the next arrival
// and the scan runs once more.
// A stalled m_tready holds the result word and the whole scan.
// Reset clears the job count, drop flag, done mask and sequencer; the job store
// itself is not cleared, only slots loaded in the current set are read.
`default_nettype none
module hrrn_job_scheduler_top #(
    parameter int MAX_PROCS  = hjs_pkg::MAX_PROCS_DEF,
    parameter int TIME_WIDTH = hjs_pkg::TIME_WIDTH_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // [15:0] arrival, [31:16] burst_length
    input  wire logic [hjs_pkg::S_TDATA_W-1:0] s_tdata,
    input  wire logic                          s_tlast,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // [5:0] job_index, [26:6] start_time, [47:27] finish_time, [68:48] wait_time,
    // [89:69] turnaround, [95:90] zero
    output logic [hjs_pkg::M_TDATA_W-1:0]      m_tdata,
    // [0] jobs_dropped
    output logic                               m_tuser,
    output logic                               m_tlast
);

    localparam int FW     = hjs_pkg::IN_FIELD_W;
    localparam int SW     = (TIME_WIDTH < FW) ? TIME_WIDTH : FW;
    localparam int IW     = $clog2(MAX_PROCS);
    localparam int CW     = $clog2(MAX_PROCS + 1);
    localparam int TIME_W = SW + IW + 1;
    localparam int NUM_W  = TIME_W + 1;
    localparam int OTW    = hjs_pkg::OUT_TIME_W;
    localparam int SAT_W  = (TIME_W > OTW) ? TIME_W : OTW;
    localparam int PAD_W  = hjs_pkg::M_TDATA_W - hjs_pkg::OUT_IDX_W - 4 * OTW;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_RD     = 3'd1;
    localparam logic [2:0] ST_EVAL   = 3'd2;
    localparam logic [2:0] ST_MUL1   = 3'd3;
    localparam logic [2:0] ST_MUL2   = 3'd4;
    localparam logic [2:0] ST_CMP    = 3'd5;
    localparam logic [2:0] ST_DECIDE = 3'd6;
    localparam logic [2:0] ST_OUT    = 3'd7;

    function automatic logic [OTW-1:0] sat_out(input logic [SAT_W-1:0] v);
        logic [OTW-1:0] r;
        if (v > SAT_W'(hjs_pkg::OUT_MAX)) begin
            r = hjs_pkg::OUT_MAX;
        end else begin
            r = v[OTW-1:0];
        end
        return r;
    endfunction

    logic [2:0]           state_reg, state_next;
    logic [CW-1:0]        cnt_reg, cnt_next;
    logic                 drop_reg, drop_next;
    logic [SW-1:0]        min_reg, min_next;
    logic [TIME_W-1:0]    time_reg, time_next;
    logic [IW-1:0]        idx_reg, idx_next;
    logic [IW-1:0]        k_reg, k_next;
    logic [MAX_PROCS-1:0] done_reg, done_next;
    logic                 have_best_reg, have_best_next;
    logic [IW-1:0]        best_idx_reg, best_idx_next;
    logic [SW-1:0]        best_arr_reg, best_arr_next;
    logic [SW-1:0]        best_bur_reg, best_bur_next;
    logic [NUM_W-1:0]     best_num_reg, best_num_next;
    logic                 have_nxt_reg, have_nxt_next;
    logic [SW-1:0]        nxt_arr_reg, nxt_arr_next;
    logic [NUM_W-1:0]     cand_num_reg, cand_num_next;

    logic [hjs_pkg::OUT_IDX_W-1:0] out_idx_reg, out_idx_next;
    logic [OTW-1:0]       out_start_reg, out_start_next;
    logic [OTW-1:0]       out_fin_reg, out_fin_next;
    logic [OTW-1:0]       out_wait_reg, out_wait_next;
    logic [OTW-1:0]       out_turn_reg, out_turn_next;
    logic                 out_last_reg, out_last_next;

    logic                 s_acc;
    logic                 full;
    logic [SW-1:0]        arr_in, bur_in, min_new;
    logic                 mem_we;
    logic [2*SW-1:0]      rd_data;
    logic [SW-1:0]        rd_arr, rd_bur;
    logic [CW-1:0]        cnt_m1;
    logic                 idx_last;
    logic                 cand_ready;
    logic [NUM_W-1:0]     cand_num;
    logic                 cand_wins;
    hjs_pkg::cmp_ctrl_t   cmp_ctrl;

    assign s_tready = (state_reg == ST_IDLE);
    assign s_acc    = s_tvalid && s_tready;
    assign full     = (cnt_reg == CW'(MAX_PROCS));
    assign arr_in   = s_tdata[SW-1:0];
    assign bur_in   = (s_tdata[FW +: SW] == '0) ? SW'(1) : s_tdata[FW +: SW];
    assign min_new  = ((cnt_reg == '0) || (arr_in < min_reg)) ? arr_in : min_reg;
    assign mem_we   = s_acc && !full;

    assign rd_arr     = rd_data[SW-1:0];
    assign rd_bur     = rd_data[2*SW-1:SW];
    assign cnt_m1     = cnt_reg - CW'(1);
    assign idx_last   = (idx_reg == cnt_m1[IW-1:0]);
    assign cand_ready = (TIME_W'(rd_arr) <= time_reg);
    assign cand_num   = NUM_W'(time_reg - TIME_W'(rd_arr)) + NUM_W'(rd_bur);

    assign cmp_ctrl = {(state_reg == ST_MUL1), (state_reg == ST_MUL2)};

    hjs_job_mem #(
        .DEPTH(MAX_PROCS),
        .AW   (IW),
        .DW   (2 * SW)
    ) u_mem (
        .aclk (aclk),
        .we   (mem_we),
        .waddr(cnt_reg[IW-1:0]),
        .wdata({bur_in, arr_in}),
        .raddr(idx_reg),
        .rdata(rd_data)
    );

    hjs_cmp_unit #(
        .NUM_W(NUM_W),
        .SW   (SW)
    ) u_cmp (
        .aclk     (aclk),
        .ctrl     (cmp_ctrl),
        .cand_num (cand_num_reg),
        .best_num (best_num_reg),
        .cand_bur (rd_bur),
        .best_bur (best_bur_reg),
        .cand_arr (rd_arr),
        .best_arr (best_arr_reg),
        .cand_wins(cand_wins)
    );

    always_comb begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        drop_next      = drop_reg;
        min_next       = min_reg;
        time_next      = time_reg;
        idx_next       = idx_reg;
        k_next         = k_reg;
        done_next      = done_reg;
        have_best_next = have_best_reg;
        best_idx_next  = best_idx_reg;
        best_arr_next  = best_arr_reg;
        best_bur_next  = best_bur_reg;
        best_num_next  = best_num_reg;
        have_nxt_next  = have_nxt_reg;
        nxt_arr_next   = nxt_arr_reg;
        cand_num_next  = cand_num_reg;
        out_idx_next   = out_idx_reg;
        out_start_next = out_start_reg;
        out_fin_next   = out_fin_reg;
        out_wait_next  = out_wait_reg;
        out_turn_next  = out_turn_reg;
        out_last_next  = out_last_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_acc) begin
                    if (full) begin
                        drop_next = 1'b1;
                    end else begin
                        cnt_next = cnt_reg + CW'(1);
                        min_next = min_new;
                    end
                    if (s_tlast) begin
                        time_next      = TIME_W'(full ? min_reg : min_new);
                        idx_next       = '0;
                        k_next         = '0;
                        have_best_next = 1'b0;
                        have_nxt_next  = 1'b0;
                        state_next     = ST_RD;
                    end
                end
            end
            ST_RD: begin
                state_next = ST_EVAL;
            end
            ST_EVAL: begin
                state_next = idx_last ? ST_DECIDE : ST_RD;
                if (!idx_last) begin
                    idx_next = idx_reg + IW'(1);
                end
                if (!done_reg[idx_reg]) begin
                    if (cand_ready) begin
                        if (!have_best_reg) begin
                            have_best_next = 1'b1;
                            best_idx_next  = idx_reg;
                            best_arr_next  = rd_arr;
                            best_bur_next  = rd_bur;
                            best_num_next  = cand_num;
                        end else begin
                            cand_num_next = cand_num;
                            idx_next      = idx_reg;
                            state_next    = ST_MUL1;
                        end
                    end else if (!have_nxt_reg || (rd_arr < nxt_arr_reg)) begin
                        have_nxt_next = 1'b1;
                        nxt_arr_next  = rd_arr;
                    end
                end
            end
            ST_MUL1: begin
                state_next = ST_MUL2;
            end
            ST_MUL2: begin
                state_next = ST_CMP;
            end
            ST_CMP: begin
                if (cand_wins) begin
                    best_idx_next = idx_reg;
                    best_arr_next = rd_arr;
                    best_bur_next = rd_bur;
                    best_num_next = cand_num_reg;
                end
                if (idx_last) begin
                    state_next = ST_DECIDE;
                end else begin
                    idx_next   = idx_reg + IW'(1);
                    state_next = ST_RD;
                end
            end
            ST_DECIDE: begin
                if (have_best_reg) begin
                    out_idx_next   = hjs_pkg::OUT_IDX_W'(best_idx_reg);
                    out_start_next = sat_out(SAT_W'(time_reg));
                    out_fin_next   = sat_out(SAT_W'(time_reg + TIME_W'(best_bur_reg)));
                    out_wait_next  = sat_out(SAT_W'(time_reg - TIME_W'(best_arr_reg)));
                    out_turn_next  = sat_out(SAT_W'(best_num_reg));
                    out_last_next  = (k_reg == cnt_m1[IW-1:0]);
                    state_next     = ST_OUT;
                end else begin
                    time_next     = TIME_W'(nxt_arr_reg);
                    idx_next      = '0;
                    have_nxt_next = 1'b0;
                    state_next    = ST_RD;
                end
            end
            ST_OUT: begin
                if (m_tready) begin
                    done_next[best_idx_reg] = 1'b1;
                    time_next      = time_reg + TIME_W'(best_bur_reg);
                    have_best_next = 1'b0;
                    have_nxt_next  = 1'b0;
                    idx_next       = '0;
                    if (out_last_reg) begin
                        cnt_next   = '0;
                        drop_next  = 1'b0;
                        done_next  = '0;
                        k_next     = '0;
                        state_next = ST_IDLE;
                    end else begin
                        k_next     = k_reg + IW'(1);
                        state_next = ST_RD;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            drop_reg      <= 1'b0;
            time_reg      <= '0;
            idx_reg       <= '0;
            k_reg         <= '0;
            done_reg      <= '0;
            have_best_reg <= 1'b0;
            have_nxt_reg  <= 1'b0;
        end else begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            drop_reg      <= drop_next;
            time_reg      <= time_next;
            idx_reg       <= idx_next;
            k_reg         <= k_next;
            done_reg      <= done_next;
            have_best_reg <= have_best_next;
            have_nxt_reg  <= have_nxt_next;
        end
    end

    always_ff @(posedge aclk) begin
        min_reg       <= min_next;
        best_idx_reg  <= best_idx_next;
        best_arr_reg  <= best_arr_next;
        best_bur_reg  <= best_bur_next;
        best_num_reg  <= best_num_next;
        nxt_arr_reg   <= nxt_arr_next;
        cand_num_reg  <= cand_num_next;
        out_idx_reg   <= out_idx_next;
        out_start_reg <= out_start_next;
        out_fin_reg   <= out_fin_next;
        out_wait_reg  <= out_wait_next;
        out_turn_reg  <= out_turn_next;
        out_last_reg  <= out_last_next;
    end

    assign m_tvalid = (state_reg == ST_OUT);
    assign m_tdata  = {{PAD_W{1'b0}}, out_turn_reg, out_wait_reg, out_fin_reg,
                       out_start_reg, out_idx_reg};
    assign m_tuser  = drop_reg;
    assign m_tlast  = out_last_reg;

endmodule
`default_nettype wire

// ===== hdl/hjs_checker.sv =====
// Port-level checker of the HRRN job scheduler, bound to the top level.
`default_nettype none
module hjs_checker (
    input wire logic                          aclk,
    input wire logic                          aresetn,
    input wire logic                          s_tready,
    input wire logic                          m_tvalid,
    input wire logic                          m_tready,
    input wire logic [hjs_pkg::M_TDATA_W-1:0] m_tdata,
    input wire logic                          m_tlast
);

    property p_out_hold;
        @(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast));
    endproperty
    a_out_hold: assert property (p_out_hold) else $error("result word changed while stalled");

    property p_no_overlap;
        @(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid);
    endproperty
    a_no_overlap: assert property (p_no_overlap) else $error("load open while scheduling");

    property p_idle_after_last;
        @(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && m_tlast) |=> (s_tready && !m_tvalid);
    endproperty
    a_idle_after_last: assert property (p_idle_after_last)
        else $error("not idle after final result");

    property p_times_order;
        @(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ((m_tdata[47:27] >= m_tdata[26:6]) && (m_tdata[89:69] >= m_tdata[68:48]));
    endproperty
    a_times_order: assert property (p_times_order) else $error("result times out of order");

    property p_reset_quiet;
        @(posedge aclk) !aresetn |=> !m_tvalid;
    endproperty
    a_reset_quiet: assert property (p_reset_quiet) else $error("result valid after reset");

endmodule

bind hrrn_job_scheduler_top hjs_checker u_hjs_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_tready(s_tready),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tlast (m_tlast)
);
`default_nettype wire
